// ===== src/ddvs_pkg.sv =====
// ----------------------------------------------------------------------------
// ddvs_pkg: shared definitions for deadlock detection with victim selection
// Field widths, parameter defaults, input modes, victim policies and
// configuration register indexes.
// ----------------------------------------------------------------------------
package ddvs_pkg;

  // Parameter defaults
  localparam int MAX_THREADS_DEF   = 16;
  localparam int MAX_RESOURCES_DEF = 8;
  localparam int COUNT_WIDTH_DEF   = 16;

  // Payload field widths
  localparam int MODE_W   = 2;
  localparam int THREAD_W = 4;
  localparam int RES_W    = 3;
  localparam int VALUE_W  = 16;
  localparam int VICTIM_W = 4;
  localparam int MASK_W   = 16;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 5;
  localparam int THREADS_CFG_W   = 5;
  localparam int RESOURCES_CFG_W = 4;
  localparam int POLICY_W        = 2;

  localparam logic [THREADS_CFG_W-1:0]   THREADS_RST   = 5'd16;
  localparam logic [RESOURCES_CFG_W-1:0] RESOURCES_RST = 4'd8;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_THREADS   = 2'd0,
    CFG_RESOURCES = 2'd1,
    CFG_POLICY    = 2'd2
  } cfg_index_t;

  typedef enum logic [MODE_W-1:0] {
    MODE_AVAIL = 2'd0,
    MODE_REQ   = 2'd1,
    MODE_AGE   = 2'd2,
    MODE_CHECK = 2'd3
  } mode_t;

  typedef enum logic [POLICY_W-1:0] {
    POL_OUT_SUM = 2'd0,
    POL_MAX_SUM = 2'd1,
    POL_YOUNG   = 2'd2,
    POL_LARGEST = 2'd3
  } policy_t;

endpackage

// ===== src/ddvs_if.sv =====
// ----------------------------------------------------------------------------
// ddvs_if: valid/ready channels for load/check items and results
// One interface per direction; the source drives valid and payload, the
// sink drives ready.
// ----------------------------------------------------------------------------
interface ddvs_item_if;
  logic                            valid;
  logic                            ready;
  logic [ddvs_pkg::MODE_W-1:0]     mode;
  logic [ddvs_pkg::THREAD_W-1:0]   thread_index;
  logic [ddvs_pkg::RES_W-1:0]      resource_index;
  logic [ddvs_pkg::VALUE_W-1:0]    value;
  logic [ddvs_pkg::VALUE_W-1:0]    max_value;

  modport source (output valid, mode, thread_index, resource_index, value, max_value,
                  input ready);
  modport sink   (input valid, mode, thread_index, resource_index, value, max_value,
                  output ready);
endinterface

interface ddvs_result_if;
  logic                            valid;
  logic                            ready;
  logic                            check_done;
  logic                            deadlock;
  logic [ddvs_pkg::VICTIM_W-1:0]   victim;
  logic [ddvs_pkg::MASK_W-1:0]     blocked_mask;

  modport source (output valid, check_done, deadlock, victim, blocked_mask, input ready);
  modport sink   (input valid, check_done, deadlock, victim, blocked_mask, output ready);
endinterface

// ===== src/deadlock_detect_victim_select.sv =====
// ----------------------------------------------------------------------------
// deadlock_detect_victim_select: resource deadlock detection, victim choice
// Holds available counts, per-thread outstanding/maximum requests and thread
// timestamps. Load items write the stores; a check item walks every thread
// and resource entry in use through one compare/accumulate unit.
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake        payload
//  item      in   valid / ready    mode, thread_index, resource_index, value, max_value
//  result    out  valid / ready    check_done, deadlock, victim, blocked_mask
//  cfg       in   cfg_we           cfg_index, cfg_data
//
//  A load item is handled in idle without leaving it and gives one all-zero result transaction.
//  A check passes each request entry in use through a memory read state
//  (S_FETCH) and a compare/accumulate state (S_ACC), and each thread in use
//  through a victim compare state (S_ROW), then ends in S_OUT.
//  After reset a clearing pass over all MAX_THREADS*MAX_RESOURCES entries zeroes the
//  request and timestamp memories; items are not taken during it.
//  One result register sits on the output: a new item is taken while it is
//  empty or being drained; a stalled result holds the block in idle, or at
//  the end of a check until the register frees up.
// ----------------------------------------------------------------------------
module deadlock_detect_victim_select #(
  parameter int MAX_THREADS   = ddvs_pkg::MAX_THREADS_DEF,
  parameter int MAX_RESOURCES = ddvs_pkg::MAX_RESOURCES_DEF,
  parameter int COUNT_WIDTH   = ddvs_pkg::COUNT_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  ddvs_item_if.sink                         item,
  ddvs_result_if.source                     result,
  input  logic                              cfg_we,
  input  logic [ddvs_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ddvs_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int DEPTH = MAX_THREADS * MAX_RESOURCES;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int TW    = (MAX_THREADS > 1) ? $clog2(MAX_THREADS) : 1;
  localparam int RW    = (MAX_RESOURCES > 1) ? $clog2(MAX_RESOURCES) : 1;
  localparam int SW    = COUNT_WIDTH + RW;

  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE  = 6'b000010,
    S_FETCH = 6'b000100,
    S_ACC   = 6'b001000,
    S_ROW   = 6'b010000,
    S_OUT   = 6'b100000
  } state_t;

  state_t state;

  // Configuration registers
  logic [ddvs_pkg::THREADS_CFG_W-1:0]   threads_in_use;
  logic [ddvs_pkg::RESOURCES_CFG_W-1:0] resources_in_use;
  logic [ddvs_pkg::POLICY_W-1:0]        victim_policy;

  // Stores
  logic [COUNT_WIDTH-1:0] avail [MAX_RESOURCES];
  logic [COUNT_WIDTH-1:0] out_mem [DEPTH];
  logic [COUNT_WIDTH-1:0] max_mem [DEPTH];
  logic [COUNT_WIDTH-1:0] age_mem [MAX_THREADS];
  logic [COUNT_WIDTH-1:0] req_q;
  logic [COUNT_WIDTH-1:0] max_q;
  logic [COUNT_WIDTH-1:0] age_q;

  // Sequencer state
  logic [AW-1:0]          clr_addr;
  logic [TW-1:0]          ti;
  logic [TW-1:0]          ti_last;
  logic [RW-1:0]          rj;
  logic [RW-1:0]          rj_last;
  logic [AW-1:0]          row_base;
  logic                   blocked_row;
  logic [SW-1:0]          score;
  logic [SW-1:0]          best;
  logic                   have;
  logic [TW-1:0]          vic;
  logic                   all_blocked;
  logic [MAX_THREADS-1:0] mask;

  // Result register
  logic                            res_valid;
  logic                            res_check;
  logic                            res_dead;
  logic [ddvs_pkg::VICTIM_W-1:0]   res_victim;
  logic [ddvs_pkg::MASK_W-1:0]     res_mask;

  // Combinational helpers
  logic                   accept;
  logic [COUNT_WIDTH-1:0] val;
  logic [COUNT_WIDTH-1:0] mval;
  logic                   t_ok;
  logic                   r_ok;
  logic [AW-1:0]          wr_addr;
  logic [AW-1:0]          rd_addr;
  logic                   out_we;
  logic [AW-1:0]          out_waddr;
  logic [COUNT_WIDTH-1:0] out_wdata;
  logic [COUNT_WIDTH-1:0] max_wdata;
  logic                   age_we;
  logic [TW-1:0]          age_waddr;
  logic [COUNT_WIDTH-1:0] age_wdata;
  logic [TW-1:0]          ti_last_next;
  logic [RW-1:0]          rj_last_next;
  logic                   blocked_next;
  logic [SW-1:0]          score_next;
  logic [SW-1:0]          final_score;
  logic                   res_free;
  logic                   res_set;
  logic [63:0]            mask_ext;
  logic [31:0]            vic_ext;

  assign res_free     = !res_valid || result.ready;
  assign item.ready   = (state == S_IDLE) && res_free;
  assign accept       = item.valid && item.ready;

  // Load a result for a load item at acceptance, or for a check at its end
  assign res_set = (accept && (ddvs_pkg::mode_t'(item.mode) != ddvs_pkg::MODE_CHECK)) ||
                   ((state == S_OUT) && res_free);

  assign val  = COUNT_WIDTH'(item.value);
  assign mval = COUNT_WIDTH'(item.max_value);
  assign t_ok = int'(item.thread_index) < MAX_THREADS;
  assign r_ok = int'(item.resource_index) < MAX_RESOURCES;
  assign wr_addr = AW'(int'(item.thread_index) * MAX_RESOURCES + int'(item.resource_index));
  assign rd_addr = row_base + AW'(rj);

  // Memory write port selection: clearing pass or load item
  always_comb begin
    out_we    = 1'b0;
    out_waddr = wr_addr;
    out_wdata = val;
    max_wdata = mval;
    age_we    = 1'b0;
    age_waddr = TW'(item.thread_index);
    age_wdata = val;
    if (state == S_CLEAR) begin
      out_we    = 1'b1;
      out_waddr = clr_addr;
      out_wdata = '0;
      max_wdata = '0;
      age_we    = int'(clr_addr) < MAX_THREADS;
      age_waddr = TW'(clr_addr);
      age_wdata = '0;
    end else if (accept) begin
      out_we = (ddvs_pkg::mode_t'(item.mode) == ddvs_pkg::MODE_REQ) && t_ok && r_ok;
      age_we = (ddvs_pkg::mode_t'(item.mode) == ddvs_pkg::MODE_AGE) && t_ok;
    end
  end

  // Request memories
  always_ff @(posedge clk) begin
    if (out_we) begin
      out_mem[out_waddr] <= out_wdata;
      max_mem[out_waddr] <= max_wdata;
    end
    req_q <= out_mem[rd_addr];
    max_q <= max_mem[rd_addr];
  end

  // Timestamp memory
  always_ff @(posedge clk) begin
    if (age_we) begin
      age_mem[age_waddr] <= age_wdata;
    end
    age_q <= age_mem[ti];
  end

  // Clamp the in-use counts to between one and the configured store size
  always_comb begin
    int nt;
    int nr;
    nt = int'(threads_in_use);
    nr = int'(resources_in_use);
    if (nt < 1) nt = 1;
    if (nt > MAX_THREADS) nt = MAX_THREADS;
    if (nr < 1) nr = 1;
    if (nr > MAX_RESOURCES) nr = MAX_RESOURCES;
    ti_last_next = TW'(nt - 1);
    rj_last_next = RW'(nr - 1);
  end

  // Shared compare/accumulate unit
  always_comb begin
    blocked_next = blocked_row || (avail[rj] < req_q);
    case (ddvs_pkg::policy_t'(victim_policy))
      ddvs_pkg::POL_OUT_SUM: score_next = score + SW'(req_q);
      ddvs_pkg::POL_MAX_SUM: score_next = score + SW'(max_q);
      ddvs_pkg::POL_LARGEST: score_next = (SW'(req_q) > score) ? SW'(req_q) : score;
      default:               score_next = score;
    endcase
    final_score = (ddvs_pkg::policy_t'(victim_policy) == ddvs_pkg::POL_YOUNG) ?
                  SW'(age_q) : score;
  end

  assign mask_ext = 64'(mask);
  assign vic_ext  = 32'(vic);

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      threads_in_use   <= ddvs_pkg::THREADS_RST;
      resources_in_use <= ddvs_pkg::RESOURCES_RST;
      victim_policy    <= ddvs_pkg::POL_OUT_SUM;
    end else if (cfg_we) begin
      case (ddvs_pkg::cfg_index_t'(cfg_index))
        ddvs_pkg::CFG_THREADS:   threads_in_use   <= cfg_data[ddvs_pkg::THREADS_CFG_W-1:0];
        ddvs_pkg::CFG_RESOURCES: resources_in_use <= cfg_data[ddvs_pkg::RESOURCES_CFG_W-1:0];
        ddvs_pkg::CFG_POLICY:    victim_policy    <= cfg_data[ddvs_pkg::POLICY_W-1:0];
        default: ;
      endcase
    end
  end

  // Available counts
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < MAX_RESOURCES; k++) begin
        avail[k] <= '0;
      end
    end else if (accept && (ddvs_pkg::mode_t'(item.mode) == ddvs_pkg::MODE_AVAIL) && r_ok) begin
      avail[RW'(item.resource_index)] <= val;
    end
  end

  // Sequencer and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      res_valid <= 1'b0;
    end else begin
      // Load a new result, or drop the one whose transaction completes
      if (res_set) begin
        res_valid <= 1'b1;
      end else if (res_valid && result.ready) begin
        res_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == AW'(DEPTH - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            if (ddvs_pkg::mode_t'(item.mode) == ddvs_pkg::MODE_CHECK) begin
              ti          <= '0;
              rj          <= '0;
              row_base    <= '0;
              ti_last     <= ti_last_next;
              rj_last     <= rj_last_next;
              blocked_row <= 1'b0;
              score       <= '0;
              best        <= '0;
              have        <= 1'b0;
              vic         <= '0;
              all_blocked <= 1'b1;
              mask        <= '0;
              state       <= S_FETCH;
            end else begin
              res_check  <= 1'b0;
              res_dead   <= 1'b0;
              res_victim <= '0;
              res_mask   <= '0;
            end
          end
        end
        S_FETCH: begin
          state <= S_ACC;
        end
        S_ACC: begin
          blocked_row <= blocked_next;
          score       <= score_next;
          if (rj == rj_last) begin
            state <= S_ROW;
          end else begin
            rj    <= rj + 1'b1;
            state <= S_FETCH;
          end
        end
        S_ROW: begin
          // Mark the thread and keep the best blocked candidate
          if (!blocked_row) begin
            all_blocked <= 1'b0;
          end else begin
            mask[ti] <= 1'b1;
            if (!have || (final_score > best)) begin
              have <= 1'b1;
              best <= final_score;
              vic  <= ti;
            end
          end
          if (ti == ti_last) begin
            state <= S_OUT;
          end else begin
            ti          <= ti + 1'b1;
            rj          <= '0;
            row_base    <= row_base + AW'(MAX_RESOURCES);
            blocked_row <= 1'b0;
            score       <= '0;
            state       <= S_FETCH;
          end
        end
        S_OUT: begin
          if (res_free) begin
            res_check  <= 1'b1;
            res_dead   <= all_blocked;
            res_victim <= all_blocked ? vic_ext[ddvs_pkg::VICTIM_W-1:0] : '0;
            res_mask   <= mask_ext[ddvs_pkg::MASK_W-1:0];
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign result.valid        = res_valid;
  assign result.check_done   = res_check;
  assign result.deadlock     = res_dead;
  assign result.victim       = res_victim;
  assign result.blocked_mask = res_mask;

  // A load result carries no check outcome
  a_load_result_zero: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_check) |-> (!res_dead && res_victim == '0 && res_mask == '0))
    else $error("load result carries check fields");

  // A deadlock implies at least one blocked thread
  a_deadlock_has_blocked: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_dead) |-> (res_mask != '0))
    else $error("deadlock reported with empty blocked mask");

  // The resource walk stays within the columns in use
  a_column_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_ACC) |-> (rj <= rj_last))
    else $error("resource column beyond last in use");

endmodule
